>>> hdl/drfs_pkg.sv
package drfs_pkg;

    // Input and output payloads
    typedef struct packed {
        logic       req_type;
        logic [7:0] x_start;
        logic [7:0] y_start;
        logic [7:0] width;
        logic [7:0] height;
        logic [15:0] color;
    } t_in;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       is_data;
        logic       last;
    } t_out;

    // Request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Display command bytes
    localparam logic [7:0] CMD_COL_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET   = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

    // Header sequence positions
    localparam logic [3:0] HDR_COL_SET     = 4'd0;
    localparam logic [3:0] HDR_COL_FIRST_H = 4'd1;
    localparam logic [3:0] HDR_COL_FIRST_L = 4'd2;
    localparam logic [3:0] HDR_COL_LAST_H  = 4'd3;
    localparam logic [3:0] HDR_COL_LAST_L  = 4'd4;
    localparam logic [3:0] HDR_ROW_SET     = 4'd5;
    localparam logic [3:0] HDR_ROW_FIRST_H = 4'd6;
    localparam logic [3:0] HDR_ROW_FIRST_L = 4'd7;
    localparam logic [3:0] HDR_ROW_LAST_H  = 4'd8;
    localparam logic [3:0] HDR_ROW_LAST_L  = 4'd9;
    localparam logic [3:0] HDR_MEM_WRITE   = 4'd10;
    localparam logic [3:0] HDR_PIXELS      = 4'd11;

    // Bytes per fill: header plus two per pixel, up to 11 + 2 * 255 * 255
    localparam int BYTE_CNT_W = 17;
    localparam int HEADER_LEN = 11;

    // Front to back command queue
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        Q_LOAD,
        Q_EMIT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  col_first;
        logic [8:0]  col_last;
        logic [7:0]  row_first;
        logic [8:0]  row_last;
        logic [15:0] color;
        logic [15:0] pixels;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

>>> hdl/drfs_front.sv
module drfs_front
    import drfs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in       i_in_data,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic                  r_busy,      n_busy;
    logic [BYTE_CNT_W-1:0] r_bytes_left, n_bytes_left;

    logic        w_accept;
    logic        w_start_ok;
    logic        w_tick_ok;
    logic [15:0] w_pixels;
    logic [BYTE_CNT_W-1:0] w_total;

    assign o_in_ready = !i_q_status.full;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_start_ok = w_accept && (i_in_data.req_type == REQ_START) && !r_busy
                        && (i_in_data.width != 8'd0) && (i_in_data.height != 8'd0);
    assign w_tick_ok  = w_accept && (i_in_data.req_type == REQ_TICK) && r_busy;

    assign w_pixels = 16'(i_in_data.width) * 16'(i_in_data.height);
    assign w_total  = {w_pixels, 1'b0} + BYTE_CNT_W'(HEADER_LEN);

    assign o_push = w_start_ok || w_tick_ok;

    always_comb begin
        o_cmd.kind      = w_start_ok ? Q_LOAD : Q_EMIT;
        o_cmd.col_first = i_in_data.x_start;
        o_cmd.row_first = i_in_data.y_start;
        o_cmd.col_last  = {1'b0, i_in_data.x_start} + {1'b0, i_in_data.width} - 9'd1;
        o_cmd.row_last  = {1'b0, i_in_data.y_start} + {1'b0, i_in_data.height} - 9'd1;
        o_cmd.color     = i_in_data.color;
        o_cmd.pixels    = w_pixels;
    end

    // Busy is tracked in item order by counting the ticks the fill will consume
    always_comb begin
        n_busy       = r_busy;
        n_bytes_left = r_bytes_left;
        if (w_start_ok) begin
            n_busy       = 1'b1;
            n_bytes_left = w_total;
        end else if (w_tick_ok) begin
            if (r_bytes_left == BYTE_CNT_W'(1)) begin
                n_busy = 1'b0;
            end
            n_bytes_left = r_bytes_left - BYTE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_bytes_left <= n_bytes_left;
    end

endmodule

>>> hdl/drfs_queue.sv
module drfs_queue
    import drfs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == CNT_W'(0));
    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> hdl/drfs_back.sv
module drfs_back
    import drfs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_head,
    input  t_q_status i_q_status,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out      o_out_data
);

    logic        r_out_valid, n_out_valid;
    t_out        r_out,       n_out;
    logic [3:0]  r_hdr_step,  n_hdr_step;
    logic        r_low_next,  n_low_next;
    logic [15:0] r_pixels_left, n_pixels_left;
    logic [7:0]  r_col_first, r_row_first;
    logic [8:0]  r_col_last,  r_row_last;
    logic [15:0] r_color;

    logic       w_load;
    logic       w_emit;
    logic [7:0] w_hdr_byte;
    logic       w_hdr_data;

    assign o_pop       = !i_q_status.empty && (!r_out_valid || i_out_ready);
    assign w_load      = o_pop && (i_head.kind == Q_LOAD);
    assign w_emit      = o_pop && (i_head.kind == Q_EMIT);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        w_hdr_data = 1'b1;
        unique case (r_hdr_step)
            HDR_COL_SET: begin
                w_hdr_byte = CMD_COL_SET;
                w_hdr_data = 1'b0;
            end
            HDR_COL_FIRST_H: w_hdr_byte = 8'h00;
            HDR_COL_FIRST_L: w_hdr_byte = r_col_first;
            HDR_COL_LAST_H:  w_hdr_byte = {7'd0, r_col_last[8]};
            HDR_COL_LAST_L:  w_hdr_byte = r_col_last[7:0];
            HDR_ROW_SET: begin
                w_hdr_byte = CMD_ROW_SET;
                w_hdr_data = 1'b0;
            end
            HDR_ROW_FIRST_H: w_hdr_byte = 8'h00;
            HDR_ROW_FIRST_L: w_hdr_byte = r_row_first;
            HDR_ROW_LAST_H:  w_hdr_byte = {7'd0, r_row_last[8]};
            HDR_ROW_LAST_L:  w_hdr_byte = r_row_last[7:0];
            default: begin
                w_hdr_byte = CMD_MEM_WRITE;
                w_hdr_data = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out         = r_out;
        n_hdr_step    = r_hdr_step;
        n_low_next    = r_low_next;
        n_pixels_left = r_pixels_left;
        if (w_load) begin
            n_hdr_step    = HDR_COL_SET;
            n_low_next    = 1'b0;
            n_pixels_left = i_head.pixels;
        end else if (w_emit) begin
            n_out_valid = 1'b1;
            n_out.last  = 1'b0;
            if (r_hdr_step != HDR_PIXELS) begin
                n_out.spi_byte = w_hdr_byte;
                n_out.is_data  = w_hdr_data;
                n_hdr_step     = r_hdr_step + 4'd1;
            end else begin
                n_out.is_data = 1'b1;
                if (!r_low_next) begin
                    n_out.spi_byte = r_color[15:8];
                    n_low_next     = 1'b1;
                end else begin
                    n_out.spi_byte = r_color[7:0];
                    n_low_next     = 1'b0;
                    if (r_pixels_left <= 16'd1) begin
                        n_out.last    = 1'b1;
                        n_pixels_left = 16'd0;
                        n_hdr_step    = HDR_COL_SET;
                    end else begin
                        n_pixels_left = r_pixels_left - 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hdr_step  <= HDR_COL_SET;
            r_low_next  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_hdr_step  <= n_hdr_step;
            r_low_next  <= n_low_next;
        end
        r_out         <= n_out;
        r_pixels_left <= n_pixels_left;
        if (w_load) begin
            r_col_first <= i_head.col_first;
            r_col_last  <= i_head.col_last;
            r_row_first <= i_head.row_first;
            r_row_last  <= i_head.row_last;
            r_color     <= i_head.color;
        end
    end

endmodule

>>> hdl/display_rectangle_fill_stream.sv
// Rectangle fill byte stream for a serial display controller.
// Input channel (i_in_valid / o_in_ready / i_in_data): a start transaction
// carries origin, size and RGB-565 colour; a tick transaction asks for the
// next byte. Starts with zero width or height, starts while a fill runs and
// ticks while idle are dropped without a result.
// Output channel (o_out_valid / i_out_ready / o_out_data): one transaction
// per accepted tick during a fill: column-set, row-set and memory-write
// headers (11 bytes), then the colour high and low byte for every pixel.
// The final byte carries last; chip select may be released after it.
// Throughput: one transaction a cycle on both sides while neither side
// stalls. On tick acceptance the accepting edge writes the command queue;
// the output register loads the byte once the queue head can be popped.
// When the receiver stalls, the output register holds and the queue fills;
// o_in_ready drops only once the queue holds two commands.
// Reset (i_rst_n low at a clock edge) empties the queue, drops any fill in
// progress and clears o_out_valid.
module display_rectangle_fill_stream
    import drfs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic      w_push;
    logic      w_pop;
    t_cmd      w_cmd;
    t_cmd      w_head;
    t_q_status w_q_status;

    drfs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    drfs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    drfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("command pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("command popped from an empty queue");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_q_status.empty)
        else $error("queue empty after a push");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> !o_in_ready)
        else $error("input ready while queue full");
`endif

endmodule

>>> tb/sv/tb_display_rectangle_fill_stream.sv
module tb_display_rectangle_fill_stream;
    timeunit 1ns;
    timeprecision 1ps;

    import drfs_pkg::*;

    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int ITEMS_PER_PHASE = 200;

    // Tracks the fill state and holds the bytes still to come out
    class rect_fill_scoreboard;
        logic        busy;
        logic [3:0]  hdr_pos;
        logic [7:0]  col_first;
        logic [8:0]  col_last;
        logic [7:0]  row_first;
        logic [8:0]  row_last;
        logic [15:0] colour;
        logic [15:0] pixels_left;
        logic        low_next;
        t_out        expected_bytes[$];
        int          errors;

        function new();
            busy        = 1'b0;
            hdr_pos     = HDR_COL_SET;
            col_first   = '0;
            col_last    = '0;
            row_first   = '0;
            row_last    = '0;
            colour      = '0;
            pixels_left = '0;
            low_next    = 1'b0;
            errors      = 0;
        endfunction

        function void note_request(t_in req);
            t_out nxt;
            if (req.req_type == REQ_START) begin
                if (!busy && req.width != 8'd0 && req.height != 8'd0) begin
                    col_first   = req.x_start;
                    row_first   = req.y_start;
                    col_last    = {1'b0, req.x_start} + {1'b0, req.width} - 9'd1;
                    row_last    = {1'b0, req.y_start} + {1'b0, req.height} - 9'd1;
                    colour      = req.color;
                    pixels_left = 16'(req.width) * 16'(req.height);
                    hdr_pos     = HDR_COL_SET;
                    low_next    = 1'b0;
                    busy        = 1'b1;
                end
                return;
            end
            if (!busy)
                return;
            nxt.is_data = 1'b1;
            nxt.last    = 1'b0;
            if (hdr_pos != HDR_PIXELS) begin
                case (hdr_pos)
                    HDR_COL_SET: begin
                        nxt.spi_byte = CMD_COL_SET;
                        nxt.is_data  = 1'b0;
                    end
                    HDR_COL_FIRST_H: nxt.spi_byte = 8'h00;
                    HDR_COL_FIRST_L: nxt.spi_byte = col_first;
                    HDR_COL_LAST_H:  nxt.spi_byte = {7'd0, col_last[8]};
                    HDR_COL_LAST_L:  nxt.spi_byte = col_last[7:0];
                    HDR_ROW_SET: begin
                        nxt.spi_byte = CMD_ROW_SET;
                        nxt.is_data  = 1'b0;
                    end
                    HDR_ROW_FIRST_H: nxt.spi_byte = 8'h00;
                    HDR_ROW_FIRST_L: nxt.spi_byte = row_first;
                    HDR_ROW_LAST_H:  nxt.spi_byte = {7'd0, row_last[8]};
                    HDR_ROW_LAST_L:  nxt.spi_byte = row_last[7:0];
                    default: begin
                        nxt.spi_byte = CMD_MEM_WRITE;
                        nxt.is_data  = 1'b0;
                    end
                endcase
                hdr_pos = hdr_pos + 4'd1;
            end else if (!low_next) begin
                nxt.spi_byte = colour[15:8];
                low_next     = 1'b1;
            end else begin
                nxt.spi_byte = colour[7:0];
                low_next     = 1'b0;
                if (pixels_left <= 16'd1) begin
                    pixels_left = '0;
                    nxt.last    = 1'b1;
                    busy        = 1'b0;
                    hdr_pos     = HDR_COL_SET;
                end else begin
                    pixels_left = pixels_left - 16'd1;
                end
            end
            expected_bytes.push_back(nxt);
        endfunction

        function void check_byte(t_out got);
            t_out want;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output transaction, expected none, got %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.spi_byte !== want.spi_byte) begin
                $display("%0t: spi_byte expected %h got %h", $time,
                         want.spi_byte, got.spi_byte);
                errors++;
            end
            if (got.is_data !== want.is_data) begin
                $display("%0t: is_data expected %b got %b", $time,
                         want.is_data, got.is_data);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %b got %b", $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    rect_fill_scoreboard sb;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    bit hold_req          = 1'b0;
    int ticks_owed        = 0;
    int counted           = 0;
    int phase_base        = 0;
    int quiet_cycles      = 0;

    display_rectangle_fill_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Input first, so a same-edge pass-through would still line up
    always @(posedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (i_in_valid && o_in_ready)
                sb.note_request(i_in_data);
            if (o_out_valid && i_out_ready)
                sb.check_byte(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Called at a falling edge, returns at a falling edge
    task automatic send_item(input t_in it);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Keeps a running count of ticks the current fill still needs
    task automatic issue(input t_in it);
        if (it.req_type == REQ_START) begin
            if (ticks_owed == 0 && it.width != 8'd0 && it.height != 8'd0) begin
                ticks_owed = HEADER_LEN + 2 * int'(it.width) * int'(it.height);
                counted++;
            end
        end else if (ticks_owed > 0) begin
            ticks_owed--;
            counted++;
        end
        send_item(it);
    endtask

    function automatic t_in random_item(input logic kind);
        logic [63:0] raw;
        t_in         it;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in)-1:0];
        it.req_type = kind;
        return it;
    endfunction

    function automatic t_in make_start(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] w, input logic [7:0] h,
                                       input logic [15:0] c);
        t_in it;
        it = random_item(REQ_START);
        it.x_start = x;
        it.y_start = y;
        it.width   = w;
        it.height  = h;
        it.color   = c;
        return it;
    endfunction

    task automatic finish_fill(input int busy_start_pct);
        while (ticks_owed > 0) begin
            if ($urandom_range(0, 99) < busy_start_pct)
                issue(random_item(REQ_START));
            else
                issue(random_item(REQ_TICK));
        end
    endtask

    task automatic run_fill(input logic [7:0] w, input logic [7:0] h, input int busy_pct);
        finish_fill(busy_pct);
        issue(make_start(8'($urandom), 8'($urandom), w, h, 16'($urandom)));
        finish_fill(busy_pct);
    endtask

    task automatic random_burst();
        int          pick;
        int          cut;
        logic [7:0]  w;
        logic [7:0]  h;
        t_in         it;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            if ($urandom_range(0, 19) == 0) begin
                w = 8'($urandom_range(1, 16));
                h = 8'($urandom_range(1, 16));
            end else begin
                w = 8'($urandom_range(1, 4));
                h = 8'($urandom_range(1, 4));
            end
            run_fill(w, h, 8);
        end else if (pick < 90) begin
            // abandoned part way; the next well-formed fill drains it first
            finish_fill(0);
            issue(make_start(8'($urandom), 8'($urandom), 8'($urandom_range(1, 3)),
                             8'($urandom_range(1, 3)), 16'($urandom)));
            cut = $urandom_range(0, ticks_owed - 1);
            repeat (cut) issue(random_item(REQ_TICK));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 2))
                    0: it = random_item(REQ_TICK);
                    1: begin
                        it = random_item(REQ_START);
                        if ($urandom_range(0, 1))
                            it.width = 8'd0;
                        else
                            it.height = 8'd0;
                    end
                    default: begin
                        it = random_item(REQ_START);
                        if (ticks_owed == 0)
                            it.height = 8'd0;
                    end
                endcase
                issue(it);
            end
        end
    endtask

    initial begin
        sb = new();
        sender_idle_pct   = 37;
        receiver_idle_pct = 52;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // tick while idle, empty rectangles, smallest fill at the far corner
        issue(random_item(REQ_TICK));
        issue(make_start(8'd10, 8'd20, 8'd0, 8'd5, 16'h1234));
        issue(make_start(8'd10, 8'd20, 8'd5, 8'd0, 16'h1234));
        issue(make_start(8'd0, 8'd0, 8'd0, 8'd0, 16'h0000));
        issue(make_start(8'hFF, 8'hFF, 8'd1, 8'd1, 16'hFFFF));
        repeat (5) issue(random_item(REQ_TICK));
        // start while busy must not disturb the running fill
        issue(make_start(8'd0, 8'd0, 8'hFF, 8'hFF, 16'h0000));
        finish_fill(0);
        issue(random_item(REQ_TICK));
        issue(make_start(8'd0, 8'd0, 8'd1, 8'd1, 16'h0000));
        finish_fill(0);

        // widest rectangle with a column end past 255, then a row end past 255
        issue(make_start(8'hFF, 8'h00, 8'hFF, 8'd1, 16'hA55A));
        finish_fill(1);
        issue(make_start(8'h10, 8'hFF, 8'd3, 8'd2, 16'h5AA5));
        finish_fill(1);

        phase_base = counted;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 37;
                    receiver_idle_pct = 52;
                end
                1: begin
                    sender_idle_pct   = 52;
                    receiver_idle_pct = 37;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                    hold_req          = 1'b1;
                    run_fill(8'd16, 8'd8, 0);
                end
            endcase
            while (counted < phase_base + (phase + 1) * ITEMS_PER_PHASE)
                random_burst();
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
